// ===== design/tea_pkg.sv =====
// tea_pkg: shared types, constants and round-sum helper for the tea block cipher
// no dependencies; used by tea_round and tea_block_cipher
package tea_pkg;

	localparam int          CYCLES_DEF = 32;
	localparam logic [31:0] DELTA      = 32'h9e3779b9;
	localparam int          WORD_W     = 32;
	localparam int          CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_WORD0 = 2'd0,
		REG_KEY_WORD1 = 2'd1,
		REG_KEY_WORD2 = 2'd2,
		REG_KEY_WORD3 = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef struct packed {
		logic              opcode;
		logic [WORD_W-1:0] half_left;
		logic [WORD_W-1:0] half_right;
	} tea_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] out_left;
		logic [WORD_W-1:0] out_right;
	} tea_out_t;

	typedef struct packed {
		logic [WORD_W-1:0] key_word0;
		logic [WORD_W-1:0] key_word1;
		logic [WORD_W-1:0] key_word2;
		logic [WORD_W-1:0] key_word3;
	} tea_key_t;

	typedef struct packed {
		logic              opcode;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} tea_pipe_t;

	// n * delta modulo 2^32
	function automatic logic [WORD_W-1:0] round_sum(input int n);
		logic [2*WORD_W-1:0] prod;
		prod = 64'(n) * 64'(DELTA);
		return prod[WORD_W-1:0];
	endfunction

endpackage

// ===== design/tea_round.sv =====
// tea_round: one feistel half-round of tea with its pipeline register
// depends on tea_pkg
module tea_round #(
	parameter logic [tea_pkg::WORD_W-1:0] SUM_ENC = tea_pkg::DELTA,
	parameter logic [tea_pkg::WORD_W-1:0] SUM_DEC = tea_pkg::round_sum(tea_pkg::CYCLES_DEF),
	parameter logic                       ODD     = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  tea_pkg::tea_pipe_t data_in,
	input  tea_pkg::tea_key_t  key,
	output logic               valid_out,
	output tea_pkg::tea_pipe_t data_out
);

	logic                       upd_left;
	logic [tea_pkg::WORD_W-1:0] x;
	logic [tea_pkg::WORD_W-1:0] target;
	logic [tea_pkg::WORD_W-1:0] ka;
	logic [tea_pkg::WORD_W-1:0] kb;
	logic [tea_pkg::WORD_W-1:0] sum;
	logic [tea_pkg::WORD_W-1:0] mix;
	logic [tea_pkg::WORD_W-1:0] upd;
	logic                       valid_s1;
	tea_pkg::tea_pipe_t         data_s1;

	// encrypt updates left on even half-rounds, decrypt on odd ones
	assign upd_left = (data_in.opcode == ODD);

	always_comb begin
		if (upd_left) begin
			x      = data_in.right;
			target = data_in.left;
			ka     = key.key_word0;
			kb     = key.key_word1;
		end else begin
			x      = data_in.left;
			target = data_in.right;
			ka     = key.key_word2;
			kb     = key.key_word3;
		end
		sum = (data_in.opcode == tea_pkg::OP_DECRYPT) ? SUM_DEC : SUM_ENC;
		mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
		upd = (data_in.opcode == tea_pkg::OP_DECRYPT) ? (target - mix) : (target + mix);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.opcode <= data_in.opcode;
			data_s1.left   <= upd_left ? upd : data_in.left;
			data_s1.right  <= upd_left ? data_in.right : upd;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

// ===== design/tea_block_cipher.sv =====
// tea_block_cipher: fully unrolled tea encrypt/decrypt pipeline, one half-round per stage
// depends on tea_pkg and tea_round
//
//  channel  signals                         dir  word
//  blk      blk_valid, blk_ready, blk       in   opcode, half_left, half_right
//  res      res_valid, res_ready, res       out  out_left, out_right
//  cfg      cfg_we, cfg_index, cfg_data     in   key_word0..key_word3
//
// one word accepted per cycle while the last stage is empty or res is taken; one
// register stage per feistel half-round, the last stage drives res
// reset clears all stage valid bits and the key registers
// a result that is not taken freezes every stage; nothing is dropped or repeated
module tea_block_cipher #(
	parameter int CYCLES = tea_pkg::CYCLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          blk_valid,
	output logic                          blk_ready,
	input  tea_pkg::tea_in_t              blk,
	output logic                          res_valid,
	input  logic                          res_ready,
	output tea_pkg::tea_out_t             res,
	input  logic                          cfg_we,
	input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tea_pkg::WORD_W-1:0]    cfg_data
);

	localparam int NSTAGE = 2 * CYCLES;

	tea_pkg::tea_key_t  key_q;
	logic               en;
	logic [NSTAGE:0]    stage_vld;
	tea_pkg::tea_pipe_t stage_data [NSTAGE+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (tea_pkg::cfg_reg_t'(cfg_index))
				tea_pkg::REG_KEY_WORD0: key_q.key_word0 <= cfg_data;
				tea_pkg::REG_KEY_WORD1: key_q.key_word1 <= cfg_data;
				tea_pkg::REG_KEY_WORD2: key_q.key_word2 <= cfg_data;
				tea_pkg::REG_KEY_WORD3: key_q.key_word3 <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

	assign en        = !stage_vld[NSTAGE] || res_ready;
	assign blk_ready = en;

	assign stage_vld[0]         = blk_valid;
	assign stage_data[0].opcode = blk.opcode;
	assign stage_data[0].left   = blk.half_left;
	assign stage_data[0].right  = blk.half_right;

	for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
		tea_round #(
			.SUM_ENC(tea_pkg::round_sum(j / 2 + 1)),
			.SUM_DEC(tea_pkg::round_sum(CYCLES - j / 2)),
			.ODD    (1'(j % 2))
		) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (stage_vld[j]),
			.data_in  (stage_data[j]),
			.key      (key_q),
			.valid_out(stage_vld[j+1]),
			.data_out (stage_data[j+1])
		);
	end

	assign res_valid     = stage_vld[NSTAGE];
	assign res.out_left  = stage_data[NSTAGE].left;
	assign res.out_right = stage_data[NSTAGE].right;

	// frozen pipeline keeps its occupancy
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stage_vld[NSTAGE:1]))
		else $error("pipeline occupancy changed during stall");

	// an accepted word lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(blk_valid && blk_ready) |=> stage_vld[1])
		else $error("accepted word missing from first stage");

	// the last stage takes what the one before it held
	a_last_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (stage_vld[NSTAGE] == $past(stage_vld[NSTAGE-1])))
		else $error("result valid does not follow previous stage");

endmodule

// ===== sim/tb_tea_block_cipher.sv =====
// tb_tea_block_cipher: self-checking bench for the tea block cipher pipeline, with
// directed and random blocks checked against a behavioral tea predictor under rotating keys
// depends on tea_pkg and tea_block_cipher
module tb_tea_block_cipher;

	localparam int TEA_CYCLES = tea_pkg::CYCLES_DEF;
	localparam int PIPE_LAT   = 2 * TEA_CYCLES;

	typedef struct packed {
		tea_pkg::op_t               op;
		logic [tea_pkg::WORD_W-1:0] left;
		logic [tea_pkg::WORD_W-1:0] right;
		logic                       typed;
		tea_pkg::tea_out_t          want;
	} blk_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          blk_valid;
	logic                          blk_ready;
	tea_pkg::tea_in_t              blk;
	logic                          res_valid;
	logic                          res_ready;
	tea_pkg::tea_out_t             res;
	logic                          cfg_we;
	logic [tea_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tea_pkg::WORD_W-1:0]    cfg_data;

	logic [tea_pkg::WORD_W-1:0] key_q [4];
	tea_pkg::tea_out_t          ciphered_q [$];
	tea_pkg::tea_out_t          head_blk;
	int                         mismatch_cnt = 0;
	bit                         steady = 1'b0;

	// typed rows hold the published all-zero key vector and its inverse
	blk_row_t dir_rows [12] = '{
		'{tea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1, {32'h41ea_3a0a, 32'h94ba_a940}},
		'{tea_pkg::OP_DECRYPT, 32'h41ea_3a0a, 32'h94ba_a940, 1'b1, {32'h0000_0000, 32'h0000_0000}},
		'{tea_pkg::OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
		'{tea_pkg::OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
		'{tea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff, 1'b0, '0},
		'{tea_pkg::OP_ENCRYPT, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
		'{tea_pkg::OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{tea_pkg::OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0, '0},
		'{tea_pkg::OP_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0, '0},
		'{tea_pkg::OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0},
		'{tea_pkg::OP_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0},
		'{tea_pkg::OP_ENCRYPT, 32'h1234_5678, 32'h9abc_def0, 1'b0, '0}
	};

	tea_block_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk       (blk),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [tea_pkg::WORD_W-1:0] feistel_mix(
		input logic [tea_pkg::WORD_W-1:0] x, s, ka, kb);
		return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
	endfunction

	function automatic tea_pkg::tea_out_t tea_transform(input tea_pkg::tea_in_t w);
		logic [tea_pkg::WORD_W-1:0] l;
		logic [tea_pkg::WORD_W-1:0] r;
		logic [tea_pkg::WORD_W-1:0] s;
		l = w.half_left;
		r = w.half_right;
		if (tea_pkg::op_t'(w.opcode) == tea_pkg::OP_ENCRYPT) begin
			s = '0;
			for (int n = 0; n < TEA_CYCLES; n++) begin
				s = s + tea_pkg::DELTA;
				l = l + feistel_mix(r, s, key_q[tea_pkg::REG_KEY_WORD0],
					key_q[tea_pkg::REG_KEY_WORD1]);
				r = r + feistel_mix(l, s, key_q[tea_pkg::REG_KEY_WORD2],
					key_q[tea_pkg::REG_KEY_WORD3]);
			end
		end else begin
			s = tea_pkg::DELTA * 32'(TEA_CYCLES);
			for (int n = 0; n < TEA_CYCLES; n++) begin
				r = r - feistel_mix(l, s, key_q[tea_pkg::REG_KEY_WORD2],
					key_q[tea_pkg::REG_KEY_WORD3]);
				l = l - feistel_mix(r, s, key_q[tea_pkg::REG_KEY_WORD0],
					key_q[tea_pkg::REG_KEY_WORD1]);
				s = s - tea_pkg::DELTA;
			end
		end
		return '{out_left: l, out_right: r};
	endfunction

	function automatic logic [tea_pkg::WORD_W-1:0] corner_word();
		int k;
		k = $urandom_range(0, tea_pkg::WORD_W - 1);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'd1 << k;
			3: return ~(32'd1 << k);
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic push_block(input tea_pkg::tea_in_t w, input tea_pkg::tea_out_t want);
		if (!steady && $urandom_range(0, 3) == 0) begin
			blk_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		blk       <= w;
		blk_valid <= 1'b1;
		do @(posedge clk); while (!blk_ready);
		ciphered_q.push_back(want);
		@(negedge clk);
	endtask

	task automatic settle();
		blk_valid <= 1'b0;
		while (ciphered_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_key(input logic [tea_pkg::WORD_W-1:0] k0, k1, k2, k3);
		logic [tea_pkg::WORD_W-1:0] kw [4];
		kw = '{k0, k1, k2, k3};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= tea_pkg::cfg_reg_t'(i);
			cfg_data  <= kw[i];
			@(posedge clk);
			key_q[i] = kw[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// random blocks, often followed by the inverse operation on the predicted word
	task automatic run_blocks(input int n);
		tea_pkg::tea_in_t  w;
		tea_pkg::tea_out_t o;
		int                sent;
		sent = 0;
		while (sent < n) begin
			w.opcode     = 1'($urandom_range(0, 1));
			w.half_left  = corner_word();
			w.half_right = corner_word();
			o = tea_transform(w);
			push_block(w, o);
			sent++;
			if ($urandom_range(0, 1)) begin
				w.opcode     = ~w.opcode;
				w.half_left  = o.out_left;
				w.half_right = o.out_right;
				push_block(w, tea_transform(w));
				sent++;
			end
		end
	endtask

	initial begin
		res_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (!steady && $urandom_range(0, 3) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			res_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (ciphered_q.size() == 0) begin
				$error("result word with no block pending: %h", res);
				mismatch_cnt++;
			end else begin
				head_blk = ciphered_q.pop_front();
				if (res.out_left !== head_blk.out_left) begin
					$error("out_left: expected %h, actual %h", head_blk.out_left, res.out_left);
					mismatch_cnt++;
				end
				if (res.out_right !== head_blk.out_right) begin
					$error("out_right: expected %h, actual %h", head_blk.out_right,
						res.out_right);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		tea_pkg::tea_in_t w;
		arst_n    = 1'b0;
		blk_valid = 1'b0;
		blk       = '0;
		cfg_we    = 1'b0;
		cfg_index = tea_pkg::REG_KEY_WORD0;
		cfg_data  = '0;
		foreach (key_q[i]) key_q[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			w.opcode     = dir_rows[i].op;
			w.half_left  = dir_rows[i].left;
			w.half_right = dir_rows[i].right;
			push_block(w, dir_rows[i].typed ? dir_rows[i].want : tea_transform(w));
		end
		settle();

		load_key('1, '1, '1, '1);
		run_blocks(280);
		settle();
		load_key(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
		run_blocks(280);
		settle();
		load_key(32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
		run_blocks(280);
		settle();
		repeat (4) begin
			load_key($urandom, $urandom, $urandom, $urandom);
			run_blocks(280);
			settle();
		end

		steady = 1'b1;
		load_key('0, '0, '0, '0);
		run_blocks(150);
		settle();
		load_key($urandom, $urandom, $urandom, $urandom);
		run_blocks(150);
		settle();
		repeat (PIPE_LAT + 8) @(posedge clk);

		if (mismatch_cnt == 0 && ciphered_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
